// ----- sv/ray_height_clip_with_caps_assert.svh -----
// Assertion macros for the checker file.
`ifndef RAY_HEIGHT_CLIP_WITH_CAPS_ASSERT_SVH
`define RAY_HEIGHT_CLIP_WITH_CAPS_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define RHC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is high.
`define RHC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define RHC_ASSERT_NEXT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("reset check failed");

`endif

// ----- sv/rhc_pkg.sv -----
package rhc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   // Numerator magnitude bits, dividend bits (one divider cell each), remainder bits.
   localparam int NB = W + 1;
   localparam int QB = NB + F;
   localparam int RB = W + 1;
   // Width of a magnitude that goes through the clamp.
   localparam int MW = ((2 * W - F) > QB) ? (2 * W - F) : QB;

   localparam int IN_BITS   = 5 * W - 1;
   localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
   localparam int OUT_DATA_W = ((W + 7) / 8) * 8;

   localparam logic [W-1:0]  POS_MAX   = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  NEG_MIN   = {1'b1, {(W-1){1'b0}}};
   localparam logic [MW-1:0] NEG_LIM_M = MW'(1) << (W - 1);
   localparam logic [MW-1:0] POS_MAX_M = NEG_LIM_M - MW'(1);

   typedef struct packed {
      logic          sat;
      logic [W-1:0]  val;
   } clamp_type;

   // Item state that travels down the divider chain.
   typedef struct packed {
      logic          vld;
      logic          use_div;
      logic          neg;
      logic          div0;
      logic          num_neg;
      logic          sat;
      logic [W-1:0]  hit;
      logic [W-1:0]  dvsr;
      logic [QB-1:0] dvnd;
      logic [RB-1:0] rem;
      logic [QB-1:0] quo;
   } div_type;

   // Signed result from a sign and a magnitude, clamped to the word range.
   function automatic clamp_type clamp_mag(input logic neg, input logic [MW-1:0] m);
      clamp_type r;
      logic [MW-1:0] nm;
      nm = ~m + MW'(1);
      r.sat = 1'b0;
      if (neg) begin
         if (m > NEG_LIM_M) begin
            r.sat = 1'b1;
            r.val = NEG_MIN;
         end else begin
            r.val = nm[W-1:0];
         end
      end else begin
         if (m > POS_MAX_M) begin
            r.sat = 1'b1;
            r.val = POS_MAX;
         end else begin
            r.val = m[W-1:0];
         end
      end
      return r;
   endfunction

endpackage

// ----- sv/rhc_front.sv -----
module rhc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  logic                 mode,
   input  logic                 caps_on,
   input  logic [rhc_pkg::W-1:0]   origin_y,
   input  logic [rhc_pkg::W-1:0]   dir_y,
   input  logic [rhc_pkg::W-1:0]   t_near,
   input  logic [rhc_pkg::W-1:0]   t_far,
   input  logic [rhc_pkg::W-2:0]   half_height,
   output rhc_pkg::div_type     out
);
   import rhc_pkg::*;

   // Stage 1: the two products.
   logic                  v1_ff, m1_ff, c1_ff;
   logic signed [2*W-1:0] p1_ff, p2_ff;
   logic [W-1:0]          oy1_ff, dy1_ff, tn1_ff, tf1_ff;
   logic [W-2:0]          h1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_vld;
      end
      if (en) begin
         m1_ff  <= mode;
         c1_ff  <= caps_on;
         p1_ff  <= $signed(dir_y) * $signed(t_near);
         p2_ff  <= $signed(dir_y) * $signed(t_far);
         oy1_ff <= origin_y;
         dy1_ff <= dir_y;
         tn1_ff <= t_near;
         tf1_ff <= t_far;
         h1_ff  <= half_height;
      end
   end

   // Stage 2: drop the fraction of each magnitude and clamp.
   logic [2*W-1:0] a1, a2;
   clamp_type      q1_in, q2_in;
   logic           v2_ff, m2_ff, c2_ff, s2_ff;
   logic [W-1:0]   q1_ff, q2_ff, oy2_ff, dy2_ff, tn2_ff, tf2_ff;
   logic [W-2:0]   h2_ff;

   always_comb begin
      a1 = p1_ff[2*W-1] ? (~p1_ff + 1'b1) : p1_ff;
      a2 = p2_ff[2*W-1] ? (~p2_ff + 1'b1) : p2_ff;
      q1_in = clamp_mag(p1_ff[2*W-1], MW'(a1 >> F));
      q2_in = clamp_mag(p2_ff[2*W-1], MW'(a2 >> F));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         m2_ff  <= m1_ff;
         c2_ff  <= c1_ff;
         s2_ff  <= q1_in.sat | q2_in.sat;
         q1_ff  <= q1_in.val;
         q2_ff  <= q2_in.val;
         oy2_ff <= oy1_ff;
         dy2_ff <= dy1_ff;
         tn2_ff <= tn1_ff;
         tf2_ff <= tf1_ff;
         h2_ff  <= h1_ff;
      end
   end

   // Stage 3: hit heights, clamped to the word range.
   logic [W:0]   s1, s2;
   logic         o1, o2;
   logic         v3_ff, m3_ff, c3_ff, s3_ff;
   logic [W-1:0] y1_ff, y2_ff, oy3_ff, dy3_ff, tn3_ff, tf3_ff;
   logic [W-2:0] h3_ff;

   always_comb begin
      s1 = {oy2_ff[W-1], oy2_ff} + {q1_ff[W-1], q1_ff};
      s2 = {oy2_ff[W-1], oy2_ff} + {q2_ff[W-1], q2_ff};
      o1 = s1[W] ^ s1[W-1];
      o2 = s2[W] ^ s2[W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         m3_ff  <= m2_ff;
         c3_ff  <= c2_ff;
         s3_ff  <= s2_ff | o1 | o2;
         y1_ff  <= o1 ? (s1[W] ? NEG_MIN : POS_MAX) : s1[W-1:0];
         y2_ff  <= o2 ? (s2[W] ? NEG_MIN : POS_MAX) : s2[W-1:0];
         oy3_ff <= oy2_ff;
         dy3_ff <= dy2_ff;
         tn3_ff <= tn2_ff;
         tf3_ff <= tf2_ff;
         h3_ff  <= h2_ff;
      end
   end

   // Stage 4: height tests, cap choice and divider setup.
   logic signed [W:0]   y1x, y2x, hx, nhx;
   logic signed [W+1:0] num;
   logic [W+1:0]        num_mag;
   logic                k1, k2, top, bot;
   logic [W-1:0]        kt1, kt2, alt;
   div_type             d_in, d_ff;

   always_comb begin
      y1x = $signed({y1_ff[W-1], y1_ff});
      y2x = $signed({y2_ff[W-1], y2_ff});
      hx  = $signed({2'b00, h3_ff});
      nhx = -hx;
      if (m3_ff) begin
         k1 = y1x > nhx;
         k2 = y2x > nhx;
      end else begin
         k1 = (y1x > nhx) && (y1x < hx);
         k2 = (y2x > nhx) && (y2x < hx);
      end
      kt1 = k1 ? tn3_ff : '0;
      kt2 = k2 ? tf3_ff : '0;
      if ((kt1 != '0) && (kt2 != '0)) begin
         alt = ($signed(kt1) < $signed(kt2)) ? kt1 : kt2;
      end else begin
         alt = (kt1 != '0) ? kt1 : kt2;
      end
      top = c3_ff && !m3_ff && (y2x < hx) && (y1x > hx);
      bot = c3_ff && (y1x < nhx) && (y2x > nhx);
      if (top) begin
         num = {hx[W], hx} - {{2{oy3_ff[W-1]}}, oy3_ff};
      end else begin
         num = {nhx[W], nhx} - {{2{oy3_ff[W-1]}}, oy3_ff};
      end
      num_mag = num[W+1] ? (~num + 1'b1) : num;

      d_in.vld     = v3_ff;
      d_in.use_div = top | bot;
      d_in.num_neg = num[W+1];
      d_in.neg     = num[W+1] ^ dy3_ff[W-1];
      d_in.div0    = (dy3_ff == '0);
      d_in.sat     = s3_ff;
      d_in.hit     = alt;
      d_in.dvsr    = dy3_ff[W-1] ? (~dy3_ff + 1'b1) : dy3_ff;
      d_in.dvnd    = {num_mag[NB-1:0], {F{1'b0}}};
      d_in.rem     = '0;
      d_in.quo     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.vld <= 1'b0;
      end else if (en) begin
         d_ff <= d_in;
      end
   end

   assign out = d_ff;

endmodule

// ----- sv/rhc_div_cell.sv -----
module rhc_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  rhc_pkg::div_type d,
   output rhc_pkg::div_type q
);
   import rhc_pkg::*;

   logic [RB-1:0] trial;
   logic          ge;
   div_type       q_in, q_ff;

   // One restoring step: bring down a dividend bit and try the subtraction.
   always_comb begin
      trial = {d.rem[RB-2:0], d.dvnd[QB-1]};
      ge    = trial >= {1'b0, d.dvsr};
      q_in      = d;
      q_in.dvnd = {d.dvnd[QB-2:0], 1'b0};
      q_in.quo  = {d.quo[QB-2:0], ge};
      q_in.rem  = ge ? (trial - {1'b0, d.dvsr}) : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.vld <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// ----- sv/ray_height_clip_with_caps.sv -----
// Height clip of a ray against a capped cylinder, cone or sphere, in Q16.16. The block
// takes one item per cycle and returns one result per item, in order, after four front
// stages for products, heights and tests, one divider cell per quotient bit of the
// 49-bit cap division, and the output register. The pipeline holds as a whole while a
// result waits on rsp_tready; the input is ready whenever the output register is empty
// or being emptied.
module ray_height_clip_with_caps (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // origin_y, dir_y, t_near, t_far, half_height, zero pad
   input  logic [rhc_pkg::IN_DATA_W-1:0]   req_tdata,
   // mode, caps_on
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit_t
   output logic [rhc_pkg::OUT_DATA_W-1:0]  rsp_tdata,
   // saturated
   output logic [0:0]                      rsp_tuser
);
   import rhc_pkg::*;

   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   div_type chain [QB+1];

   rhc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_vld      (req_tvalid),
      .mode        (req_tuser[0]),
      .caps_on     (req_tuser[1]),
      .origin_y    (req_tdata[W-1:0]),
      .dir_y       (req_tdata[2*W-1:W]),
      .t_near      (req_tdata[3*W-1:2*W]),
      .t_far       (req_tdata[4*W-1:3*W]),
      .half_height (req_tdata[5*W-2:4*W]),
      .out         (chain[0])
   );

   // Divider chain, one quotient bit per cell.
   for (genvar i = 0; i < QB; i++) begin : g_cell
      rhc_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d     (chain[i]),
         .q     (chain[i+1])
      );
   end

   // Output select and clamp of the quotient.
   div_type      tail;
   clamp_type    qc;
   logic [W-1:0] hit_in;
   logic         sat_in;
   logic         vld_ff;
   logic [W-1:0] hit_ff;
   logic         sat_ff;

   always_comb begin
      tail = chain[QB];
      qc   = clamp_mag(tail.neg, MW'(tail.quo));
      if (!tail.use_div) begin
         hit_in = tail.hit;
         sat_in = tail.sat;
      end else if (tail.div0) begin
         hit_in = tail.num_neg ? NEG_MIN : POS_MAX;
         sat_in = 1'b1;
      end else begin
         hit_in = qc.val;
         sat_in = tail.sat | qc.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= tail.vld;
      end
      if (en) begin
         hit_ff <= hit_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid   = vld_ff;
   assign rsp_tdata    = OUT_DATA_W'(hit_ff);
   assign rsp_tuser[0] = sat_ff;

endmodule

// ----- sv/rhc_checker.sv -----
module rhc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready
);
`include "ray_height_clip_with_caps_assert.svh"

   // A waiting result stays offered.
   `RHC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // Reset empties the output register.
   `RHC_ASSERT_NEXT_RST(a_rst_empty, reset, !rsp_tvalid)
   // An empty output register never blocks the input.
   `RHC_ASSERT_IMPL(a_rdy_empty, !rsp_tvalid, req_tready)
   // A result being taken frees the input in the same cycle.
   `RHC_ASSERT_IMPL(a_rdy_drain, rsp_tvalid && rsp_tready, req_tready)

endmodule

bind ray_height_clip_with_caps rhc_checker u_rhc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps

// Scoreboard for the height clip: predicts hit distance and saturation per item.
class clip_scoreboard;
   typedef struct {
      logic [31:0] hit;
      logic        sat;
   } clip_result;

   clip_result pending[$];
   int         errors;
   int         checked;
   bit         sat_seen;

   // Clamp a sign and a magnitude to the signed word range.
   function automatic longint clamp_signed(bit neg, logic [127:0] m, ref bit sat);
      if (neg) begin
         if (m > 128'h8000_0000) begin
            sat = 1;
            return -64'sd2147483648;
         end
         return -longint'(m[63:0]);
      end
      if (m > 128'h7FFF_FFFF) begin
         sat = 1;
         return 64'sd2147483647;
      end
      return longint'(m[63:0]);
   endfunction

   function automatic longint clamp_word(longint s, ref bit sat);
      if (s > 64'sd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (s < -64'sd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return s;
   endfunction

   function automatic longint fixed_mul(longint a, longint b, ref bit sat);
      logic [127:0] ma, mb, p;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p = (ma * mb) >> 16;
      return clamp_signed((a < 0) != (b < 0), p, sat);
   endfunction

   function automatic longint fixed_div(longint n, longint d, ref bit sat);
      logic [127:0] mn, md, q;
      if (d == 0) begin
         sat = 1;
         return (n < 0) ? -64'sd2147483648 : 64'sd2147483647;
      end
      mn = (n < 0) ? -n : n;
      md = (d < 0) ? -d : d;
      q = (mn << 16) / md;
      return clamp_signed((n < 0) != (d < 0), q, sat);
   endfunction

   // Predict the result of one accepted item.
   function void note_item(bit sphere, logic [31:0] oy_b, logic [31:0] dy_b,
                           logic [31:0] tn_b, logic [31:0] tf_b, logic [30:0] h_b,
                           bit caps);
      longint oy, dy, tn, tf, h, y1, y2, k1, k2, hit;
      bit sat;
      clip_result r;
      oy = longint'($signed(oy_b));
      dy = longint'($signed(dy_b));
      tn = longint'($signed(tn_b));
      tf = longint'($signed(tf_b));
      h = longint'(h_b);
      sat = 0;
      k1 = 0;
      k2 = 0;
      y1 = clamp_word(oy + fixed_mul(dy, tn, sat), sat);
      y2 = clamp_word(oy + fixed_mul(dy, tf, sat), sat);
      if (sphere) begin
         if (y1 > -h) k1 = tn;
         if (y2 > -h) k2 = tf;
      end else begin
         if (y1 > -h && y1 < h) k1 = tn;
         if (y2 > -h && y2 < h) k2 = tf;
      end
      if (caps && !sphere && y2 < h && y1 > h) hit = fixed_div(h - oy, dy, sat);
      else if (caps && y1 < -h && y2 > -h) hit = fixed_div(-h - oy, dy, sat);
      else if (k1 != 0 && k2 != 0) hit = (k1 < k2) ? k1 : k2;
      else hit = (k1 != 0) ? k1 : k2;
      r.hit = hit[31:0];
      r.sat = sat;
      if (sat) sat_seen = 1;
      pending.push_back(r);
   endfunction

   // Compare one result with the oldest prediction.
   function void check_result(logic [31:0] hit, logic sat);
      clip_result e;
      checked++;
      if (pending.size() == 0) begin
         errors++;
         $display("%0t: unexpected result expected none actual hit=%h sat=%b",
                  $time, hit, sat);
         return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) begin
         errors++;
         $display("%0t: hit_t expected %h actual %h", $time, e.hit, hit);
      end
      if (sat !== e.sat) begin
         errors++;
         $display("%0t: saturated expected %b actual %b", $time, e.sat, sat);
      end
   endfunction
endclass

module tb;
   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [31:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   clip_scoreboard board = new();
   int  cycles = 0;
   bit  calm = 0;
   bit  hold_off = 0;
   int  sent = 0;

   always #5 clock = ~clock;

   ray_height_clip_with_caps uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // Timeout guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Accepted items feed the predictor, accepted results go to the check.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_item(req_tuser[0], req_tdata[31:0], req_tdata[63:32],
                         req_tdata[95:64], req_tdata[127:96], req_tdata[158:128],
                         req_tuser[1]);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tuser[0]);
   end

   // Receiver: random stall bursts, plus one long hold-off.
   initial begin
      int n;
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (150) @(negedge clock);
            hold_off = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            rsp_tready <= 0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_tready <= 1;
            @(negedge clock);
         end
      end
   end

   // Offer one item and wait until it is taken.
   task automatic send_item(bit sphere, logic [31:0] oy, logic [31:0] dy,
                            logic [31:0] tn, logic [31:0] tf, logic [30:0] h, bit caps);
      int n;
      if (!calm && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 3);
         req_tvalid <= 0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {1'b0, h, tf, tn, dy, oy};
      req_tuser <= {caps, sphere};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // Mostly a well-formed ray near the shape height, with crossings of the caps; one case in five is fully random.
   task automatic send_ray();
      logic [31:0] oy, dy, tn, tf;
      logic [30:0] h;
      case ($urandom_range(0, 4))
         0: begin
            oy = $urandom;
            dy = $urandom;
            tn = $urandom;
            tf = $urandom;
            h = 31'($urandom);
         end
         default: begin
            h = 31'($urandom_range(1, 32'h00100000));
            oy = $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
            dy = $signed($urandom_range(0, 32'h00040000)) - 32'sh00020000;
            tn = $urandom_range(0, 32'h00080000);
            tf = tn + $urandom_range(0, 32'h00080000);
         end
      endcase
      send_item(1'($urandom_range(0, 1)), oy, dy, tn, tf, h, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int m;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // Directed: field extremes, both modes, caps, saturation, zero cap distance.
      send_item(0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 1);
      send_item(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 31'h0, 0);
      send_item(0, 0, 0, 0, 0, 0, 0);
      send_item(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 1);
      // Top cap crossing, bottom cap crossing, sphere bottom cap.
      send_item(0, 32'h00030000, 32'hFFFF0000, 32'h00000000, 32'h00030000, 31'h00010000, 1);
      send_item(0, 32'hFFFD0000, 32'h00010000, 32'h00000000, 32'h00030000, 31'h00010000, 1);
      send_item(1, 32'hFFFD0000, 32'h00010000, 32'h00000000, 32'h00030000, 31'h00010000, 1);
      // Top crossing again with caps off; both kept hits; one kept hit.
      send_item(0, 32'h00030000, 32'hFFFF0000, 32'h00000000, 32'h00030000, 31'h00010000, 0);
      send_item(0, 0, 32'h00010000, 32'h00008000, 32'h00004000, 31'h00010000, 0);
      send_item(0, 0, 32'h00010000, 32'h00008000, 32'h00050000, 31'h00010000, 0);
      // Cap plane exactly at the origin gives a zero distance.
      send_item(0, 32'hFFFF0000, 32'h00010000, 32'hFFFF0000, 32'h00020000, 31'h00010000, 1);
      // Tiny direction, ray far above the shape: no cap is crossed and no hit is kept.
      send_item(0, 32'h40000000, 32'hFFFFFFFF, 32'h00000000, 32'h7FFFFFFF, 31'h00010000, 1);
      // Random part with a long receiver hold-off in the middle.
      for (m = 0; m < 500; m++) begin
         if (m == 150) hold_off = 1;
         if (m == 420) calm = 1;
         send_ray();
      end
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("Ran %0d items in both modes with caps on and off, %0d results checked.",
               sent, board.checked);
      $display("Cap crossings, saturation (seen: %0d) and a long output stall were covered.",
               board.sat_seen);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
